/* hw/rtl/hbm_pkg.sv */
`timescale 1ns / 1ps

package hbm_pkg;

  // Fixed field widths of the block's ports and registers.
  localparam int HW  = 16;  // height sample width
  localparam int KW  = 12;  // softness register width
  localparam int FW  = 13;  // blend factor register width
  localparam int MDW = 4;   // blend mode register width

  // Blend mode codes.
  localparam logic [MDW-1:0] MODE_MIX     = 4'd0;
  localparam logic [MDW-1:0] MODE_ADD     = 4'd1;
  localparam logic [MDW-1:0] MODE_SUB     = 4'd2;
  localparam logic [MDW-1:0] MODE_MUL     = 4'd3;
  localparam logic [MDW-1:0] MODE_MIN     = 4'd4;
  localparam logic [MDW-1:0] MODE_MAX     = 4'd5;
  localparam logic [MDW-1:0] MODE_SMIN    = 4'd6;
  localparam logic [MDW-1:0] MODE_SMAX    = 4'd7;
  localparam logic [MDW-1:0] MODE_OVERLAY = 4'd8;
  localparam logic [MDW-1:0] MODE_SCREEN  = 4'd9;
  localparam logic [MDW-1:0] MODE_DIFF    = 4'd10;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_FACTOR = 2'd1;
  localparam logic [1:0] REG_SOFT   = 2'd2;
  localparam logic [1:0] REG_MASK   = 2'd3;

  localparam logic [KW-1:0] SOFT_RESET   = 12'd410;
  localparam logic [FW-1:0] FACTOR_RESET = 13'd2048;

endpackage

/* hw/rtl/hbm_div_step.sv */
`timescale 1ns / 1ps

// One restoring division step: tries to subtract the divisor shifted by SH
// and sets quotient bit SH when it fits.
module hbm_div_step import hbm_pkg::*; #(
  parameter int FB = 12,
  parameter int SH = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic [KW:0]         dv,
  input  logic [FB+KW:0]      rem_in,
  input  logic [FB-1:0]       q_in,
  output logic [FB+KW:0]      rem_out,
  output logic [FB-1:0]       q_out
);

  localparam int RMW = FB + KW + 1;

  logic [RMW-1:0] trial;
  logic           fits;
  logic [RMW-1:0] rem_next;
  logic [FB-1:0]  q_next;

  always_comb begin
    trial    = RMW'(dv) << SH;
    fits     = rem_in >= trial;
    rem_next = fits ? rem_in - trial : rem_in;
    q_next   = q_in;
    q_next[SH] = fits;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      q_out   <= q_next;
    end
  end

endmodule

/* hw/rtl/heightmap_blend_modes.sv */
`timescale 1ns / 1ps

// Heightmap blend pipeline. Each input beat carries samples A and B of one
// pixel plus a mask weight, all signed fixed point with FRAC_BITS fraction
// bits, and yields one output beat with the blended height saturated to
// 16 bits. The mode, factor, softness and mask enable come from the write
// port and must only change while no beat is in flight. The datapath is a
// pipeline of FRAC_BITS + 8 register stages, and a new beat can enter
// every cycle unless an output stall backs up to the input. The depth
// is set by the smooth min/max weight, which divides by twice the
// softness with one restoring step per stage; every beat passes through
// those stages whatever the mode so that order is kept. Each stage holds
// a valid bit and moves on when the stage after it is empty or moving,
// so output stalls back up no further than needed; bubbles are squeezed out.
module heightmap_blend_modes import hbm_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic           clk,
  input  logic           rst,
  // Configuration write port.
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [FW-1:0]  cfg_data,
  // Input stream.
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [47:0]    s_axis_tdata,   // height_a [15:0], height_b [31:16],
                                         // mask_weight [47:32]
  // Output stream.
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [15:0]    m_axis_tdata    // blended [15:0]
);

  localparam int FB  = FRAC_BITS;
  localparam int OW  = (FB + 2 > HW + 1) ? FB + 2 : HW + 1;  // operand width
  localparam int PW  = 2 * OW;                                // product width
  localparam int YW  = PW + OW;                               // second product
  localparam int ZW  = YW + 1;                                // rounding sums
  localparam int RW  = (FB > 14) ? FB + 6 : 36 - FB;          // blend result
  localparam int SW  = RW + OW + 1;                           // mask sum
  localparam int NW  = FB + HW + 3;                           // smooth numerator
  localparam int RMW = FB + KW + 1;                           // remainder
  localparam int L   = FB + 8;                                // stage count

  localparam int S_IN  = 0;
  localparam int S_N   = 1;
  localparam int S_FL  = 2;
  localparam int S_P   = FB + 3;
  localparam int S_Y1  = FB + 4;
  localparam int S_Y2  = FB + 5;
  localparam int S_M1  = FB + 6;
  localparam int S_OUT = FB + 7;

  typedef logic signed [OW-1:0] op_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [YW-1:0] y_t;
  typedef logic signed [ZW-1:0] z_t;
  typedef logic signed [RW-1:0] r_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [NW-1:0] num_t;
  typedef logic signed [HW-1:0] h_t;

  localparam op_t ONE_S  = op_t'(1) <<< FB;
  localparam op_t HALF_S = op_t'(1) <<< (FB - 1);

  // Rounds to nearest with ties toward +infinity, then drops SH bits.
  function automatic r_t rnd(input z_t x, input int sh);
    z_t t;
    t = (x + (z_t'(1) <<< (sh - 1))) >>> sh;
    return r_t'(t);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [MDW-1:0] blend_mode;
  logic [FW-1:0]  blend_factor;
  logic [KW-1:0]  softness;
  logic           mask_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode   <= MODE_MIX;
      blend_factor <= FACTOR_RESET;
      softness     <= SOFT_RESET;
      mask_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   blend_mode   <= cfg_data[MDW-1:0];
        REG_FACTOR: blend_factor <= cfg_data;
        REG_SOFT:   softness     <= cfg_data[KW-1:0];
        REG_MASK:   mask_enable  <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Softness of zero is treated as one. The divisor is twice the softness.
  logic [KW-1:0] kk;
  logic [KW:0]   dv;
  op_t           fc;

  assign kk = (softness == '0) ? KW'(1) : softness;
  assign dv = {kk, 1'b0};
  // Factors above one clamp to one.
  assign fc = (op_t'({1'b0, blend_factor}) > ONE_S) ? ONE_S : op_t'({1'b0, blend_factor});

  // ---------------------------------------------------------------------
  // Stage valid bits and the advance chain. A stage loads when it is empty
  // or when the stage after it is loading too.
  // ---------------------------------------------------------------------
  logic [L-1:0] v;
  logic [L:0]   en;

  assign en[L] = m_axis_tready;
  for (genvar i = 0; i < L; i++) begin : g_adv
    assign en[i] = !v[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < L; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? s_axis_tvalid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v[S_OUT];

  // ---------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------
  h_t a0, b0, mw0;

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      a0  <= s_axis_tdata[15:0];
      b0  <= s_axis_tdata[31:16];
      mw0 <= s_axis_tdata[47:32];
    end
  end

  // ---------------------------------------------------------------------
  // Smooth min/max numerator and the clamped mask weight.
  // ---------------------------------------------------------------------
  h_t   a1, b1;
  op_t  m1;
  num_t n1;
  logic signed [HW:0] sd;
  num_t n_next;
  op_t  m_next;

  always_comb begin
    sd = (blend_mode == MODE_SMAX) ? ($signed({a0[HW-1], a0}) - $signed({b0[HW-1], b0}))
                                   : ($signed({b0[HW-1], b0}) - $signed({a0[HW-1], a0}));
    n_next = ((num_t'(sd) + num_t'({1'b0, kk})) <<< FB) + num_t'({1'b0, kk});
    if (op_t'(mw0) < op_t'(0)) begin
      m_next = '0;
    end else if (op_t'(mw0) > ONE_S) begin
      m_next = ONE_S;
    end else begin
      m_next = op_t'(mw0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_N]) begin
      a1 <= a0;
      b1 <= b0;
      m1 <= m_next;
      n1 <= n_next;
    end
  end

  // ---------------------------------------------------------------------
  // Clamp detection, then the divider steps. The weight is zero for a
  // negative numerator and one when the quotient would reach one, so the
  // divider only has to produce FB quotient bits.
  // ---------------------------------------------------------------------
  h_t             ad  [0:FB];
  h_t             bd  [0:FB];
  op_t            md  [0:FB];
  logic           lod [0:FB];
  logic           hid [0:FB];
  logic [RMW-1:0] remd[0:FB];
  logic [FB-1:0]  qd  [0:FB];
  logic           lo_next, hi_next;

  assign lo_next = n1[NW-1];
  assign hi_next = !lo_next && (n1 >= (num_t'({1'b0, dv}) <<< FB));

  always_ff @(posedge clk) begin
    if (en[S_FL]) begin
      ad[0]   <= a1;
      bd[0]   <= b1;
      md[0]   <= m1;
      lod[0]  <= lo_next;
      hid[0]  <= hi_next;
      remd[0] <= (lo_next || hi_next) ? '0 : n1[RMW-1:0];
      qd[0]   <= '0;
    end
  end

  for (genvar j = 0; j < FB; j++) begin : g_div
    hbm_div_step #(
      .FB (FB),
      .SH (FB - 1 - j)
    ) u_step (
      .clk     (clk),
      .en      (en[S_FL + 1 + j]),
      .dv      (dv),
      .rem_in  (remd[j]),
      .q_in    (qd[j]),
      .rem_out (remd[j+1]),
      .q_out   (qd[j+1])
    );

    always_ff @(posedge clk) begin
      if (en[S_FL + 1 + j]) begin
        ad[j+1]  <= ad[j];
        bd[j+1]  <= bd[j];
        md[j+1]  <= md[j];
        lod[j+1] <= lod[j];
        hid[j+1] <= hid[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // First products. Two multipliers whose operands depend on the mode.
  // ---------------------------------------------------------------------
  op_t   dw, ap, bp;
  op_t   x1, y1m, x2, y2m;
  h_t    a_p, b_p;
  op_t   m_p, d_p;
  prod_t pm1, pm2;
  logic  ov_lo;

  always_comb begin
    dw = lod[FB] ? op_t'(0) : (hid[FB] ? ONE_S : op_t'({1'b0, qd[FB]}));
    ap = op_t'(ad[FB]);
    bp = op_t'(bd[FB]);
    ov_lo = ap < HALF_S;
    x1 = '0;
    y1m = '0;
    x2 = '0;
    y2m = '0;
    unique case (blend_mode)
      MODE_MIX: begin
        x1 = ap;  y1m = ONE_S - fc;
        x2 = bp;  y2m = fc;
      end
      MODE_ADD, MODE_SUB: begin
        x1 = bp;  y1m = fc;
      end
      MODE_MUL: begin
        x1 = ap;  y1m = bp;
        x2 = ap;  y2m = ONE_S - fc;
      end
      MODE_SMIN, MODE_SMAX: begin
        x1 = ap - bp;  y1m = dw;
        x2 = op_t'({1'b0, kk});  y2m = dw;
      end
      MODE_OVERLAY: begin
        x1  = ov_lo ? ap : ONE_S - ap;
        y1m = ov_lo ? bp : ONE_S - bp;
      end
      MODE_SCREEN: begin
        x1 = ONE_S - ap;  y1m = ONE_S - bp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[S_P]) begin
      pm1 <= x1 * y1m;
      pm2 <= x2 * y2m;
      a_p <= ad[FB];
      b_p <= bd[FB];
      m_p <= md[FB];
      d_p <= dw;
    end
  end

  // ---------------------------------------------------------------------
  // Second product: the factor for multiply, (ONE - d) for smooth modes.
  // ---------------------------------------------------------------------
  prod_t ymul_a;
  op_t   ymul_b;
  y_t    y1;
  prod_t pm1_y, pm2_y;
  h_t    a_y, b_y;
  op_t   m_y;

  always_comb begin
    if (blend_mode == MODE_MUL) begin
      ymul_a = pm1;
      ymul_b = fc;
    end else begin
      ymul_a = pm2;
      ymul_b = ONE_S - d_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_Y1]) begin
      y1    <= ymul_a * ymul_b;
      pm1_y <= pm1;
      pm2_y <= pm2;
      a_y   <= a_p;
      b_y   <= b_p;
      m_y   <= m_p;
    end
  end

  // ---------------------------------------------------------------------
  // Rounding and mode selection.
  // ---------------------------------------------------------------------
  r_t  r_next, ra, rb;
  r_t  r2;
  h_t  a_r;
  op_t m_r;

  always_comb begin
    ra = r_t'(a_y);
    rb = r_t'(b_y);
    unique case (blend_mode)
      MODE_MIX:  r_next = rnd(z_t'(pm1_y) + z_t'(pm2_y), FB);
      MODE_ADD:  r_next = ra + rnd(z_t'(pm1_y), FB);
      MODE_SUB:  r_next = ra - rnd(z_t'(pm1_y), FB);
      MODE_MUL:  r_next = rnd(z_t'(y1) + (z_t'(pm2_y) <<< FB), 2 * FB);
      MODE_MIN:  r_next = (ra < rb) ? ra : rb;
      MODE_MAX:  r_next = (ra > rb) ? ra : rb;
      MODE_SMIN: r_next = rb + rnd((z_t'(pm1_y) <<< FB) - z_t'(y1), 2 * FB);
      MODE_SMAX: r_next = rb + rnd((z_t'(pm1_y) <<< FB) + z_t'(y1), 2 * FB);
      MODE_OVERLAY: begin
        if (op_t'(a_y) < HALF_S) begin
          r_next = rnd(z_t'(pm1_y) <<< 1, FB);
        end else begin
          r_next = r_t'(ONE_S) - rnd(z_t'(pm1_y) <<< 1, FB);
        end
      end
      MODE_SCREEN: r_next = r_t'(ONE_S) - rnd(z_t'(pm1_y), FB);
      MODE_DIFF:   r_next = (ra > rb) ? ra - rb : rb - ra;
      default:     r_next = ra;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[S_Y2]) begin
      r2  <= r_next;
      a_r <= a_y;
      m_r <= m_y;
    end
  end

  // ---------------------------------------------------------------------
  // Mask products.
  // ---------------------------------------------------------------------
  prod_t              pa;
  logic signed [RW+OW-1:0] pr;
  r_t                 r3;

  always_ff @(posedge clk) begin
    if (en[S_M1]) begin
      pa <= a_r * (ONE_S - m_r);
      pr <= r2 * m_r;
      r3 <= r2;
    end
  end

  // ---------------------------------------------------------------------
  // Mask mix, saturation and the output register.
  // ---------------------------------------------------------------------
  sum_t msum, fin;
  h_t   sat;

  always_comb begin
    msum = (sum_t'(pa) + sum_t'(pr) + (sum_t'(1) <<< (FB - 1))) >>> FB;
    fin  = mask_enable ? msum : sum_t'(r3);
    if (fin > sum_t'(32767)) begin
      sat = 16'sh7fff;
    end else if (fin < -sum_t'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = h_t'(fin);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      m_axis_tdata <= sat;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // Input back-pressure only happens when every stage is full and the
  // output is stalled.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  // A clamped-low weight never picks up quotient bits.
  assert property (@(posedge clk) disable iff (rst)
    (v[S_FL + FB] && lod[FB]) |-> (qd[FB] == '0))
    else $error("divider produced bits for a clamped numerator");

  // After the last step the remainder is below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    v[S_FL + FB] |-> (remd[FB] < RMW'(dv)))
    else $error("divider remainder not reduced");

  // A beat held at the output keeps its valid bit on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (v[S_OUT] && !m_axis_tready) |=> v[S_OUT])
    else $error("stalled result dropped");

endmodule
